// ----- design/note_event_recorder_macros.svh -----
// Assertion macros used by the note event recorder checker.
`ifndef NOTE_EVENT_RECORDER_MACROS_SVH
`define NOTE_EVENT_RECORDER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define NER_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define NER_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- design/ner_pkg.sv -----
// Types, constants and helper functions of the note event recorder.
package ner_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int REQ_W    = 2;
    localparam int TIME_W   = 32;
    localparam int CH_W     = 5;
    localparam int PITCH_W  = 7;
    localparam int VEL_W    = 7;
    localparam int IDX_W    = 8;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 9;

    localparam int CH_KEYS   = 16;
    localparam int CHK_W     = 4;
    localparam int KEY_W     = CHK_W + PITCH_W;
    localparam int MAP_DEPTH = 1 << KEY_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_NOTE_ON   = 2'd0,
        REQ_NOTE_OFF  = 2'd1,
        REQ_CLOSE_ALL = 2'd2,
        REQ_READ      = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_NO_OPEN = 2'd1,
        ST_NO_NOTE = 2'd2
    } status_t;

    // Per-slot note attributes kept side by side in one memory
    typedef struct packed {
        logic [CH_W-1:0]    ch;
        logic [PITCH_W-1:0] pitch;
        logic [VEL_W-1:0]   vel;
    } ner_meta_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic ready;
        logic fetch;
        logic close;
        logic store;
        logic walk_rd;
        logic clear;
        logic finish;
    } ner_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic      req_valid;
        req_type_t in_op;
        req_type_t op;
        logic      out_free;
        logic      map_hit;
        logic      held_zero;
        logic      walk_last;
        logic      clr_last;
    } ner_stat_t;

    // Map key: channel clamped to 1..16, then channel-1 above the pitch
    function automatic logic [KEY_W-1:0] key_of(input logic [CH_W-1:0]    ch,
                                                input logic [PITCH_W-1:0] pitch);
        logic [CH_W-1:0] c;
        if (ch == '0) begin
            c = CH_W'(1);
        end else if (ch > CH_W'(CH_KEYS)) begin
            c = CH_W'(CH_KEYS);
        end else begin
            c = ch;
        end
        c = c - CH_W'(1);
        return {c[CHK_W-1:0], pitch};
    endfunction

endpackage

// ----- design/ner_req_if.sv -----
// Request channel: one note event word per handshake.
interface ner_req_if;
    logic                         valid;
    logic                         ready;
    logic [ner_pkg::REQ_W-1:0]    req_type;
    logic [ner_pkg::TIME_W-1:0]   event_time;
    logic [ner_pkg::CH_W-1:0]     channel;
    logic [ner_pkg::PITCH_W-1:0]  pitch;
    logic [ner_pkg::VEL_W-1:0]    velocity;
    logic [ner_pkg::IDX_W-1:0]    read_index;

    modport source (output valid, req_type, event_time, channel, pitch, velocity,
                    read_index, input ready);
    modport sink   (input valid, req_type, event_time, channel, pitch, velocity,
                    read_index, output ready);
endinterface

// ----- design/ner_rsp_if.sv -----
// Response channel: one result word per handshake.
interface ner_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ner_pkg::STATUS_W-1:0]  status;
    logic [ner_pkg::TIME_W-1:0]    note_start;
    logic [ner_pkg::TIME_W-1:0]    note_end;
    logic                          note_sounding;
    logic [ner_pkg::CH_W-1:0]      note_channel;
    logic [ner_pkg::PITCH_W-1:0]   note_pitch;
    logic [ner_pkg::VEL_W-1:0]     note_velocity;
    logic [ner_pkg::HELD_W-1:0]    notes_held;

    modport source (output valid, status, note_start, note_end, note_sounding,
                    note_channel, note_pitch, note_velocity, notes_held, input ready);
    modport sink   (input valid, status, note_start, note_end, note_sounding,
                    note_channel, note_pitch, note_velocity, notes_held, output ready);
endinterface

// ----- design/ner_ctrl.sv -----
// Controller state machine of the note event recorder.
module ner_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  ner_pkg::ner_stat_t stat,
    output ner_pkg::ner_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_CLOSE,
        S_STORE,
        S_READ,
        S_WALK,
        S_WALK_END,
        S_RESPOND
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode commands and next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (stat.req_valid)
                begin
                    unique case (stat.in_op) inside
                        ner_pkg::REQ_NOTE_ON, ner_pkg::REQ_NOTE_OFF:
                        begin
                            state_next = S_FETCH;
                        end
                        ner_pkg::REQ_CLOSE_ALL:
                        begin
                            state_next = stat.held_zero ? S_RESPOND : S_WALK;
                        end
                        default:
                        begin
                            state_next = S_READ;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                cmd.fetch = 1'b1;
                if (stat.op == ner_pkg::REQ_NOTE_OFF && !stat.map_hit)
                begin
                    state_next = S_RESPOND;
                end
                else
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                cmd.close  = 1'b1;
                state_next = (stat.op == ner_pkg::REQ_NOTE_ON) ? S_STORE : S_RESPOND;
            end
            S_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = S_RESPOND;
            end
            S_READ:
            begin
                state_next = S_RESPOND;
            end
            S_WALK:
            begin
                cmd.walk_rd = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_WALK_END;
                end
            end
            S_WALK_END:
            begin
                state_next = S_RESPOND;
            end
            S_RESPOND:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Hold state; reset starts the map clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/ner_dpath.sv -----
// Datapath of the note event recorder: slot ring, key map, counters, result register.
module ner_dpath #(
    parameter int CAPACITY = ner_pkg::CAPACITY_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ner_pkg::ner_cmd_t  cmd,
    output ner_pkg::ner_stat_t stat,
    ner_req_if.sink            req,
    ner_rsp_if.source          rsp
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > ner_pkg::IDX_W) ? CNT_W : ner_pkg::IDX_W;
    localparam int SUM_W  = ((SLOT_W > ner_pkg::IDX_W) ? SLOT_W : ner_pkg::IDX_W) + 1;
    localparam int TW     = ner_pkg::TIME_W;

    // Memories
    logic [TW-1:0]       start_mem [CAPACITY];
    logic [TW-1:0]       end_mem   [CAPACITY];
    logic                open_mem  [CAPACITY];
    ner_pkg::ner_meta_t  meta_mem  [CAPACITY];
    logic [SLOT_W:0]     map_mem   [ner_pkg::MAP_DEPTH];

    // Registered read data
    logic [TW-1:0]       start_rd_reg;
    logic [TW-1:0]       end_rd_reg;
    logic                open_rd_reg;
    ner_pkg::ner_meta_t  meta_rd_reg;
    logic [SLOT_W:0]     map_rd_reg;

    // Request and working registers
    ner_pkg::req_type_t          op_reg;
    logic [TW-1:0]               evt_time_reg;
    ner_pkg::ner_meta_t          req_meta_reg;
    logic [ner_pkg::KEY_W-1:0]   key_reg;
    logic                        miss_reg;
    logic                        hit_reg;
    logic [SLOT_W-1:0]           hit_slot_reg;
    logic [SLOT_W-1:0]           ws_reg;
    logic [CNT_W-1:0]            held_reg;
    logic [ner_pkg::KEY_W-1:0]   clr_cnt_reg;
    logic [SLOT_W-1:0]           walk_cnt_reg;
    logic                        pend_reg;
    logic [SLOT_W-1:0]           pend_slot_reg;

    // Result register
    logic                            rsp_valid_reg;
    ner_pkg::status_t                status_reg;
    logic [TW-1:0]                   note_start_reg;
    logic [TW-1:0]                   note_end_reg;
    logic                            note_sounding_reg;
    ner_pkg::ner_meta_t              note_meta_reg;
    logic [ner_pkg::HELD_W-1:0]      notes_held_reg;

    logic                        accept;
    logic                        held_full;
    logic [SUM_W-1:0]            oldest;
    logic [SUM_W-1:0]            rsum;
    logic [SLOT_W-1:0]           rslot;
    logic                        miss_in;
    logic                        rd_en;
    logic [SLOT_W-1:0]           start_ra;
    logic [SLOT_W-1:0]           aux_ra;
    logic [TW-1:0]               end_time;
    logic                        evict;
    logic [ner_pkg::KEY_W-1:0]   rd_key;
    logic                        end_we;
    logic [SLOT_W-1:0]           end_wa;
    logic [TW-1:0]               end_wd;
    logic                        open_we;
    logic [SLOT_W-1:0]           open_wa;
    logic                        open_wd;
    logic                        map_we;
    logic [ner_pkg::KEY_W-1:0]   map_wa;
    logic [SLOT_W:0]             map_wd;
    logic [CNT_W-1:0]            held_after;
    logic [SLOT_W-1:0]           ws_after;
    logic                        read_ok;

    assign accept    = req.valid && cmd.ready;
    assign req.ready = cmd.ready;
    assign held_full = (held_reg == CNT_W'(CAPACITY));

    // Locate the n-th oldest slot: the ring starts at zero until it wraps
    always_comb
    begin
        oldest = held_full ? SUM_W'(ws_reg) : '0;
        rsum   = oldest + SUM_W'(req.read_index);
        if (rsum >= SUM_W'(CAPACITY))
        begin
            rsum = rsum - SUM_W'(CAPACITY);
        end
        rslot   = rsum[SLOT_W-1:0];
        miss_in = (CMP_W'(req.read_index) >= CMP_W'(held_reg));
    end

    // Slot read addresses
    assign rd_en    = accept || cmd.fetch || cmd.walk_rd;
    assign start_ra = cmd.fetch   ? map_rd_reg[SLOT_W-1:0] :
                      cmd.walk_rd ? walk_cnt_reg : rslot;
    assign aux_ra   = cmd.fetch   ? ws_reg :
                      cmd.walk_rd ? walk_cnt_reg : rslot;

    // End of a closed note never lies before its start
    assign end_time = (evt_time_reg > start_rd_reg) ? evt_time_reg : start_rd_reg;
    assign rd_key   = ner_pkg::key_of(meta_rd_reg.ch, meta_rd_reg.pitch);

    // Overwritten slot still sounding, and not the note just closed
    assign evict = held_full && open_rd_reg && !(hit_reg && hit_slot_reg == ws_reg);

    // Slot write selection
    always_comb
    begin
        end_we  = 1'b0;
        end_wa  = ws_reg;
        end_wd  = '0;
        open_we = 1'b0;
        open_wa = ws_reg;
        open_wd = 1'b0;
        if (cmd.close && hit_reg)
        begin
            end_we  = 1'b1;
            end_wa  = hit_slot_reg;
            end_wd  = end_time;
            open_we = 1'b1;
            open_wa = hit_slot_reg;
        end
        else if (cmd.store)
        begin
            end_we  = 1'b1;
            open_we = 1'b1;
            open_wd = 1'b1;
        end
        else if (pend_reg && open_rd_reg)
        begin
            end_we  = 1'b1;
            end_wa  = pend_slot_reg;
            end_wd  = end_time;
            open_we = 1'b1;
            open_wa = pend_slot_reg;
        end
    end

    // Map write selection
    always_comb
    begin
        map_we = 1'b0;
        map_wa = key_reg;
        map_wd = '0;
        if (cmd.clear)
        begin
            map_we = 1'b1;
            map_wa = clr_cnt_reg;
        end
        else if (cmd.close && op_reg == ner_pkg::REQ_NOTE_OFF)
        begin
            map_we = 1'b1;
        end
        else if (cmd.close && op_reg == ner_pkg::REQ_NOTE_ON && evict)
        begin
            map_we = 1'b1;
            map_wa = rd_key;
        end
        else if (cmd.store)
        begin
            map_we = 1'b1;
            map_wd = {1'b1, ws_reg};
        end
        else if (pend_reg && open_rd_reg)
        begin
            map_we = 1'b1;
            map_wa = rd_key;
        end
    end

    // Slot memories
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            start_mem[ws_reg] <= evt_time_reg;
            meta_mem[ws_reg]  <= req_meta_reg;
        end
        if (end_we)
        begin
            end_mem[end_wa] <= end_wd;
        end
        if (open_we)
        begin
            open_mem[open_wa] <= open_wd;
        end
        if (rd_en)
        begin
            start_rd_reg <= start_mem[start_ra];
            end_rd_reg   <= end_mem[aux_ra];
            open_rd_reg  <= open_mem[aux_ra];
            meta_rd_reg  <= meta_mem[aux_ra];
        end
    end

    // Key map memory
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_wa] <= map_wd;
        end
        if (accept)
        begin
            map_rd_reg <= map_mem[ner_pkg::key_of(req.channel, req.pitch)];
        end
    end

    // Latch the request word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg             <= ner_pkg::req_type_t'(req.req_type);
            evt_time_reg       <= req.event_time;
            req_meta_reg.ch    <= req.channel;
            req_meta_reg.pitch <= req.pitch;
            req_meta_reg.vel   <= req.velocity;
            key_reg            <= ner_pkg::key_of(req.channel, req.pitch);
            miss_reg           <= miss_in;
        end
        if (cmd.fetch)
        begin
            hit_reg      <= map_rd_reg[SLOT_W];
            hit_slot_reg <= map_rd_reg[SLOT_W-1:0];
        end
        if (cmd.walk_rd)
        begin
            pend_slot_reg <= walk_cnt_reg;
        end
    end

    assign held_after = (op_reg == ner_pkg::REQ_NOTE_ON && !held_full) ?
                        held_reg + CNT_W'(1) : held_reg;
    assign ws_after   = (ws_reg == SLOT_W'(CAPACITY - 1)) ? '0 : ws_reg + SLOT_W'(1);
    assign read_ok    = (op_reg == ner_pkg::REQ_READ) && !miss_reg;

    // Control registers: ring pointers, sweep counters, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg        <= '0;
            held_reg      <= '0;
            clr_cnt_reg   <= '0;
            walk_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.walk_rd;
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + ner_pkg::KEY_W'(1);
            end
            if (accept)
            begin
                walk_cnt_reg <= '0;
            end
            else if (cmd.walk_rd)
            begin
                walk_cnt_reg <= walk_cnt_reg + SLOT_W'(1);
            end
            if (cmd.finish && op_reg == ner_pkg::REQ_NOTE_ON)
            begin
                ws_reg   <= ws_after;
                held_reg <= held_after;
            end
            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (op_reg == ner_pkg::REQ_NOTE_OFF && !hit_reg)
            begin
                status_reg <= ner_pkg::ST_NO_OPEN;
            end
            else if (op_reg == ner_pkg::REQ_READ && miss_reg)
            begin
                status_reg <= ner_pkg::ST_NO_NOTE;
            end
            else
            begin
                status_reg <= ner_pkg::ST_DONE;
            end
            note_start_reg    <= read_ok ? start_rd_reg : '0;
            note_end_reg      <= read_ok ? end_rd_reg : '0;
            note_sounding_reg <= read_ok && open_rd_reg;
            note_meta_reg     <= read_ok ? meta_rd_reg : '0;
            notes_held_reg    <= ner_pkg::HELD_W'(held_after);
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.note_start    = note_start_reg;
    assign rsp.note_end      = note_end_reg;
    assign rsp.note_sounding = note_sounding_reg;
    assign rsp.note_channel  = note_meta_reg.ch;
    assign rsp.note_pitch    = note_meta_reg.pitch;
    assign rsp.note_velocity = note_meta_reg.vel;
    assign rsp.notes_held    = notes_held_reg;

    // Status towards the controller
    always_comb
    begin
        stat.req_valid = req.valid;
        stat.in_op     = ner_pkg::req_type_t'(req.req_type);
        stat.op        = op_reg;
        stat.out_free  = !rsp_valid_reg || rsp.ready;
        stat.map_hit   = map_rd_reg[SLOT_W];
        stat.held_zero = (held_reg == '0);
        stat.walk_last = ((CNT_W'(walk_cnt_reg) + CNT_W'(1)) == held_reg);
        stat.clr_last  = &clr_cnt_reg;
    end

endmodule

// ----- design/note_event_recorder.sv -----
// A note-on passes fetch, close, store and respond; a note-off fetch, close and respond
// (no close without an open note); a read the read and respond states; and a close-all a
// walk of the held slots, one slot a cycle, then walk end and respond (respond alone if
// none are held). Map and slot reads are registered. The next word is taken once the
// result is registered; the result register lets a finished result wait while the next
// word is accepted. Reset clears the 2048 map entries, one a cycle, before any word.
module note_event_recorder #(
    parameter int CAPACITY = ner_pkg::CAPACITY_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    ner_req_if.sink    req,
    ner_rsp_if.source  rsp
);

    ner_pkg::ner_cmd_t  cmd;
    ner_pkg::ner_stat_t stat;

    // Sequence each request
    ner_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Hold notes, key map and result
    ner_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ----- design/ner_checker.sv -----
// Port-level checks of the note event recorder and their binding to the top level.
`include "note_event_recorder_macros.svh"

module ner_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic [ner_pkg::REQ_W-1:0]     req_type,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [ner_pkg::STATUS_W-1:0]  status,
    input logic [ner_pkg::TIME_W-1:0]    note_start,
    input logic [ner_pkg::TIME_W-1:0]    note_end,
    input logic                          note_sounding,
    input logic [ner_pkg::CH_W-1:0]      note_channel,
    input logic [ner_pkg::PITCH_W-1:0]   note_pitch,
    input logic [ner_pkg::VEL_W-1:0]     note_velocity,
    input logic [ner_pkg::HELD_W-1:0]    notes_held
);

    logic                          req_fire;
    logic                          rsp_fire;
    logic [1:0]                    outst_reg;
    logic [1:0]                    outst_next;
    logic [1:0]                    outst_left;
    logic [ner_pkg::REQ_W-1:0]     head_type_reg;
    logic [ner_pkg::REQ_W-1:0]     head_type_next;
    logic [ner_pkg::REQ_W-1:0]     tail_type_reg;
    logic [ner_pkg::REQ_W-1:0]     tail_type_next;
    logic [ner_pkg::HELD_W-1:0]    last_held_reg;
    logic [ner_pkg::HELD_W-1:0]    held_step;

    assign req_fire   = req_valid && req_ready;
    assign rsp_fire   = rsp_valid && rsp_ready;
    assign outst_next = outst_reg + {1'b0, req_fire} - {1'b0, rsp_fire};
    assign outst_left = outst_reg - {1'b0, rsp_fire};
    assign held_step  = last_held_reg + ner_pkg::HELD_W'(1);

    // Queue the kinds of the words still owed a response, oldest first
    always_comb
    begin
        head_type_next = rsp_fire ? tail_type_reg : head_type_reg;
        tail_type_next = tail_type_reg;
        if (req_fire)
        begin
            if (outst_left == 2'd0)
            begin
                head_type_next = req_type;
            end
            else
            begin
                tail_type_next = req_type;
            end
        end
    end

    // Track words in flight, their request kinds and the last count seen
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg     <= '0;
            head_type_reg <= '0;
            tail_type_reg <= '0;
            last_held_reg <= '0;
        end
        else
        begin
            outst_reg     <= outst_next;
            head_type_reg <= head_type_next;
            tail_type_reg <= tail_type_next;
            if (rsp_fire)
            begin
                last_held_reg <= notes_held;
            end
        end
    end

    `NER_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(notes_held) && $stable(status) && $stable(note_start), "response word changed while stalled")
    `NER_ASSERT_NOW(a_rsp_owed, rsp_fire, outst_reg != 2'd0, "response without an accepted request")
    `NER_ASSERT_NOW(a_held_step, rsp_fire, notes_held == last_held_reg || notes_held == held_step, "held count moved by more than one note")
    `NER_ASSERT_NOW(a_nonread_zero, rsp_valid && head_type_reg != ner_pkg::REQ_READ, note_start == '0 && note_end == '0 && !note_sounding && note_channel == '0 && note_pitch == '0 && note_velocity == '0 && status != ner_pkg::ST_NO_NOTE, "note fields set on a non-read result")
    `NER_ASSERT_NOW(a_sounding_end, rsp_valid && note_sounding, note_end == '0, "sounding note reports an end time")

endmodule

bind note_event_recorder ner_checker u_ner_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_type      (req.req_type),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .note_start    (rsp.note_start),
    .note_end      (rsp.note_end),
    .note_sounding (rsp.note_sounding),
    .note_channel  (rsp.note_channel),
    .note_pitch    (rsp.note_pitch),
    .note_velocity (rsp.note_velocity),
    .notes_held    (rsp.notes_held)
);
